### src/kotc_pkg.sv
`timescale 1ns / 1ps

package kotc_pkg;

	localparam int SLOTS   = 1024;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int PRB_W   = $clog2(SLOTS + 1);
	localparam int KEY_W   = 31;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 64;
	localparam int PROD_W  = KEY_W + CNT_W;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

### src/kotc_ram.sv
`timescale 1ns / 1ps

module kotc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/key_occurrence_count_table_unit.sv
`timescale 1ns / 1ps

// Counts key occurrences in a linearly probed table of SLOTS entries kept in
// one single-port-read synchronous RAM. Each probe is one registered RAM
// read; an insert passes the probe and done states, a query also a multiply
// and an accumulate state, with one further probe for each further slot
// visited, up to SLOTS probes on a full table. One item is worked at a time;
// the result register lets the next item enter while a result waits. After
// reset a clearing pass walks all SLOTS (1024) RAM entries, during which
// items are stalled.
module key_occurrence_count_table_unit
	import kotc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             mode,
	input  logic [KEY_W-1:0] key,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [CNT_W-1:0] count,
	output logic [SUM_W-1:0] running_total,
	output logic             table_full
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_nxt;
	logic [PRB_W-1:0]    probes_q;
	logic                mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                full_q;
	logic [PROD_W-1:0]   product_s1;
	logic [SUM_W-1:0]    sum_q;
	logic                result_valid_q;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_entry;
	logic [IDX_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0]  rd_raw;
	entry_t              rd_entry;
	logic                accept;
	logic                hit;
	logic                last_probe;
	logic                load_out;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);
	assign rd_entry   = entry_t'(rd_raw);
	assign hit        = rd_entry.valid && (rd_entry.key == key_q);
	assign last_probe = (probes_q == PRB_W'(SLOTS - 1));
	assign idx_nxt    = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign load_out   = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = IDX_W'(key % SLOTS);
		end else begin
			rd_addr = idx_nxt;
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_entry = '{valid: 1'b0, key: key_q, count: '0};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == ST_PROBE && mode_q == MODE_INSERT) begin
			if (!rd_entry.valid) begin
				wr_en    = 1'b1;
				wr_entry = '{valid: 1'b1, key: key_q, count: CNT_W'(1)};
			end else if (hit) begin
				wr_en    = 1'b1;
				wr_entry = '{valid: 1'b1, key: key_q,
					count: (&rd_entry.count) ? rd_entry.count : rd_entry.count + 1'b1};
			end
		end
	end

	kotc_ram #(
		.DEPTH (SLOTS),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (ENTRY_W'(wr_entry)),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (!rd_entry.valid || hit || last_probe) begin
						state_q <= (mode_q == MODE_QUERY) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= sum_q + SUM_W'(product_s1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			key_q    <= key;
			idx_q    <= IDX_W'(key % SLOTS);
			probes_q <= '0;
		end
		if (state_q == ST_PROBE) begin
			if (hit) begin
				full_q <= 1'b0;
				if (mode_q == MODE_QUERY) begin
					cnt_q <= rd_entry.count;
				end else begin
					cnt_q <= (&rd_entry.count) ? rd_entry.count : rd_entry.count + 1'b1;
				end
			end else if (!rd_entry.valid) begin
				full_q <= 1'b0;
				cnt_q  <= (mode_q == MODE_QUERY) ? '0 : CNT_W'(1);
			end else if (last_probe) begin
				// every slot visited, key absent
				full_q <= (mode_q == MODE_INSERT);
				cnt_q  <= '0;
			end else begin
				idx_q    <= idx_nxt;
				probes_q <= probes_q + 1'b1;
			end
		end
		if (state_q == ST_MUL) begin
			product_s1 <= PROD_W'(key_q) * PROD_W'(cnt_q);
		end
		if (load_out) begin
			count         <= cnt_q;
			running_total <= sum_q;
			table_full    <= full_q;
		end
	end

	assign result_valid = result_valid_q;

	a_sum_only_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ACC |=> sum_q == $past(sum_q))
		else $error("running total moved outside accumulate step");

	a_full_has_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && table_full |-> count == '0)
		else $error("dropped insert reported nonzero count");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> probes_q < PRB_W'(SLOTS))
		else $error("probe count ran past table size");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_CLEAR || state_q == ST_PROBE)
		else $error("ram write outside clear or probe");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> state_q == ST_CLEAR || state_q == ST_IDLE)
		else $error("left clearing pass early");

endmodule
